/* rtl/li3_pkg.sv */
`timescale 1ns / 1ps

package li3_pkg;

   // Default width of one signed relative move field.
   localparam int MOVE_BITS_DEFAULT = 24;

   // Action codes carried by an input item.
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_DISABLED   = 2'd1,
      STATUS_BUSY       = 2'd2,
      STATUS_NO_MOVE    = 2'd3
   } status_type;

   // Step codes, two-bit signed.
   localparam logic signed [1:0] STEP_NONE = 2'sb00;
   localparam logic signed [1:0] STEP_FWD  = 2'sb01;
   localparam logic signed [1:0] STEP_BACK = 2'sb11;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // Per-move control recorded at load: dominant axis and backward bits (x, y, z).
   typedef struct packed {
      axis_type   dominant;
      logic [2:0] backward;
   } move_ctrl_type;

endpackage

/* rtl/li3_load_plan.sv */
`timescale 1ns / 1ps

module li3_load_plan
   import li3_pkg::*;
#(
   parameter int MOVE_BITS = MOVE_BITS_DEFAULT
) (
   input  logic signed [MOVE_BITS-1:0] move_dx,
   input  logic signed [MOVE_BITS-1:0] move_dy,
   input  logic signed [MOVE_BITS-1:0] move_dz,
   output move_ctrl_type               ctrl,
   output logic [MOVE_BITS-2:0]        dominant_length,
   output logic [MOVE_BITS-2:0]        minor_length_a,
   output logic [MOVE_BITS-2:0]        minor_length_b
);

   localparam int MAG_BITS = MOVE_BITS - 1;
   localparam logic [MAG_BITS-1:0] MAG_LIMIT = {MAG_BITS{1'b1}};

   // Absolute value; the most negative code saturates to the largest magnitude.
   function automatic logic [MAG_BITS-1:0] magnitude_of(input logic [MOVE_BITS-1:0] raw);
      logic [MOVE_BITS-1:0] negated;
      negated = ~raw + 1'b1;
      if (!raw[MOVE_BITS-1]) begin
         return raw[MAG_BITS-1:0];
      end else if (negated[MOVE_BITS-1]) begin
         return MAG_LIMIT;
      end else begin
         return negated[MAG_BITS-1:0];
      end
   endfunction

   logic [MAG_BITS-1:0] mag_x;
   logic [MAG_BITS-1:0] mag_y;
   logic [MAG_BITS-1:0] mag_z;

   assign mag_x = magnitude_of(move_dx);
   assign mag_y = magnitude_of(move_dy);
   assign mag_z = magnitude_of(move_dz);

   // Longest axis wins; ties go to x, then y.
   always_comb begin
      ctrl.backward = {move_dz[MOVE_BITS-1], move_dy[MOVE_BITS-1], move_dx[MOVE_BITS-1]};
      if (mag_x >= mag_y && mag_x >= mag_z) begin
         ctrl.dominant = AXIS_X;
      end else if (mag_y >= mag_z) begin
         ctrl.dominant = AXIS_Y;
      end else begin
         ctrl.dominant = AXIS_Z;
      end
   end

   // Minor axes in x, y, z order, skipping the dominant one.
   always_comb begin
      unique case (ctrl.dominant)
         AXIS_X: begin
            dominant_length = mag_x;
            minor_length_a  = mag_y;
            minor_length_b  = mag_z;
         end
         AXIS_Y: begin
            dominant_length = mag_y;
            minor_length_a  = mag_x;
            minor_length_b  = mag_z;
         end
         default: begin
            dominant_length = mag_z;
            minor_length_a  = mag_x;
            minor_length_b  = mag_y;
         end
      endcase
   end

endmodule

/* rtl/li3_minor_step.sv */
`timescale 1ns / 1ps

module li3_minor_step
   import li3_pkg::*;
#(
   parameter int MOVE_BITS = MOVE_BITS_DEFAULT
) (
   input  logic signed [MOVE_BITS:0]   error_term,
   input  logic [MOVE_BITS-2:0]        minor_length,
   input  logic [MOVE_BITS-2:0]        dominant_length,
   output logic signed [MOVE_BITS:0]   error_next,
   output logic                        step
);

   logic signed [MOVE_BITS:0] diff;

   // Subtract the minor length; on going negative, step and add the dominant length back.
   assign diff       = error_term - $signed({2'b00, minor_length});
   assign step       = diff[MOVE_BITS];
   assign error_next = step ? (diff + $signed({2'b00, dominant_length})) : diff;

endmodule

/* rtl/three_axis_line_step_interpolator.sv */
`timescale 1ns / 1ps

// A result item is registered and shown in the cycle after its input item is accepted.
// Throughput: one item per cycle; req_ready stays high while the result register
//   is empty or its item is being taken, so load and tick items run back to back.
// Reset (synchronous, active high): no move running, steppers enabled, result
//   register empty.
module three_axis_line_step_interpolator
   import li3_pkg::*;
#(
   parameter int MOVE_BITS = MOVE_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_action,
   input  logic signed [MOVE_BITS-1:0] req_move_dx,
   input  logic signed [MOVE_BITS-1:0] req_move_dy,
   input  logic signed [MOVE_BITS-1:0] req_move_dz,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic signed [1:0]           rsp_step_x,
   output logic signed [1:0]           rsp_step_y,
   output logic signed [1:0]           rsp_step_z,
   output logic                        rsp_move_done,
   // configuration
   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data
);

   localparam int MAG_BITS = MOVE_BITS - 1;
   localparam int ERR_BITS = MOVE_BITS + 1;

   // Configuration register.
   logic enabled_ff;

   // Move state.
   logic                       move_active_ff, move_active_in;
   move_ctrl_type              ctrl_ff, ctrl_in;
   logic [MAG_BITS-1:0]        steps_left_ff, steps_left_in;
   logic [MAG_BITS-1:0]        dom_len_ff, dom_len_in;
   logic [MAG_BITS-1:0]        minor_a_ff, minor_a_in;
   logic [MAG_BITS-1:0]        minor_b_ff, minor_b_in;
   logic signed [ERR_BITS-1:0] err_a_ff, err_a_in;
   logic signed [ERR_BITS-1:0] err_b_ff, err_b_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic signed [1:0] step_x_ff, step_x_in;
   logic signed [1:0] step_y_ff, step_y_in;
   logic signed [1:0] step_z_ff, step_z_in;
   logic              done_ff, done_in;

   // Load decode outputs.
   move_ctrl_type       plan_ctrl;
   logic [MAG_BITS-1:0] plan_dom_len;
   logic [MAG_BITS-1:0] plan_minor_a;
   logic [MAG_BITS-1:0] plan_minor_b;

   // Tick unit outputs.
   logic signed [ERR_BITS-1:0] tick_err_a;
   logic signed [ERR_BITS-1:0] tick_err_b;
   logic                       tick_step_a;
   logic                       tick_step_b;
   logic [2:0]                 tick_axis_step;   // z, y, x

   logic accept;

   li3_load_plan #(
      .MOVE_BITS (MOVE_BITS)
   ) u_load_plan (
      .move_dx         (req_move_dx),
      .move_dy         (req_move_dy),
      .move_dz         (req_move_dz),
      .ctrl            (plan_ctrl),
      .dominant_length (plan_dom_len),
      .minor_length_a  (plan_minor_a),
      .minor_length_b  (plan_minor_b)
   );

   li3_minor_step #(
      .MOVE_BITS (MOVE_BITS)
   ) u_minor_a (
      .error_term      (err_a_ff),
      .minor_length    (minor_a_ff),
      .dominant_length (dom_len_ff),
      .error_next      (tick_err_a),
      .step            (tick_step_a)
   );

   li3_minor_step #(
      .MOVE_BITS (MOVE_BITS)
   ) u_minor_b (
      .error_term      (err_b_ff),
      .minor_length    (minor_b_ff),
      .dominant_length (dom_len_ff),
      .error_next      (tick_err_b),
      .step            (tick_step_b)
   );

   // Accept while the result register is empty or draining this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Place the two minor step flags back onto their axes; the dominant axis always steps.
   always_comb begin
      unique case (ctrl_ff.dominant)
         AXIS_X:  tick_axis_step = {tick_step_b, tick_step_a, 1'b1};
         AXIS_Y:  tick_axis_step = {tick_step_b, 1'b1, tick_step_a};
         default: tick_axis_step = {1'b1, tick_step_b, tick_step_a};
      endcase
   end

   function automatic logic signed [1:0] step_code(input logic stepping, input logic backward);
      if (!stepping) begin
         return STEP_NONE;
      end else if (backward) begin
         return STEP_BACK;
      end else begin
         return STEP_FWD;
      end
   endfunction

   always_comb begin
      // hold by default
      move_active_in = move_active_ff;
      ctrl_in        = ctrl_ff;
      steps_left_in  = steps_left_ff;
      dom_len_in     = dom_len_ff;
      minor_a_in     = minor_a_ff;
      minor_b_in     = minor_b_ff;
      err_a_in       = err_a_ff;
      err_b_in       = err_b_ff;

      // drop the shown item when taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      step_z_in    = step_z_ff;
      done_in      = done_ff;

      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_OK;
         step_x_in    = STEP_NONE;
         step_y_in    = STEP_NONE;
         step_z_in    = STEP_NONE;
         done_in      = 1'b0;

         if (req_action == ACTION_LOAD) begin
            if (!enabled_ff) begin
               // disabled wins over busy
               status_in = STATUS_DISABLED;
            end else if (move_active_ff) begin
               status_in = STATUS_BUSY;
            end else begin
               // record the new move; both error terms start at half the dominant length
               ctrl_in        = plan_ctrl;
               dom_len_in     = plan_dom_len;
               minor_a_in     = plan_minor_a;
               minor_b_in     = plan_minor_b;
               err_a_in       = $signed({3'b000, plan_dom_len[MAG_BITS-1:1]});
               err_b_in       = $signed({3'b000, plan_dom_len[MAG_BITS-1:1]});
               steps_left_in  = plan_dom_len;
               move_active_in = (plan_dom_len != '0);
            end
         end else if (!move_active_ff) begin
            status_in = STATUS_NO_MOVE;
         end else begin
            // advance one step of the running move
            err_a_in      = tick_err_a;
            err_b_in      = tick_err_b;
            step_x_in     = step_code(tick_axis_step[0], ctrl_ff.backward[0]);
            step_y_in     = step_code(tick_axis_step[1], ctrl_ff.backward[1]);
            step_z_in     = step_code(tick_axis_step[2], ctrl_ff.backward[2]);
            steps_left_in = steps_left_ff - 1'b1;
            // an active move always has steps left, so one left means this is the last
            if (steps_left_ff == {{(MAG_BITS-1){1'b0}}, 1'b1}) begin
               move_active_in = 1'b0;
               done_in        = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff     <= 1'b1;
         move_active_ff <= 1'b0;
         ctrl_ff        <= '{dominant: AXIS_X, backward: 3'b000};
         steps_left_ff  <= '0;
         dom_len_ff     <= '0;
         minor_a_ff     <= '0;
         minor_b_ff     <= '0;
         err_a_ff       <= '0;
         err_b_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            enabled_ff <= csr_wr_data;
         end
         move_active_ff <= move_active_in;
         ctrl_ff        <= ctrl_in;
         steps_left_ff  <= steps_left_in;
         dom_len_ff     <= dom_len_in;
         minor_a_ff     <= minor_a_in;
         minor_b_ff     <= minor_b_in;
         err_a_ff       <= err_a_in;
         err_b_ff       <= err_b_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload; no reset needed.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      step_x_ff <= step_x_in;
      step_y_ff <= step_y_in;
      step_z_ff <= step_z_in;
      done_ff   <= done_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_step_x    = step_x_ff;
   assign rsp_step_y    = step_y_ff;
   assign rsp_step_z    = step_z_ff;
   assign rsp_move_done = done_ff;

endmodule

/* rtl/li3_checker.sv */
`timescale 1ns / 1ps

module li3_checker
   import li3_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_action,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_status,
   input logic signed [1:0]           rsp_step_x,
   input logic signed [1:0]           rsp_step_y,
   input logic signed [1:0]           rsp_step_z,
   input logic                        rsp_move_done
);

   logic req_take;
   logic steps_zero;

   assign req_take   = req_valid && req_ready;
   assign steps_zero = (rsp_step_x == STEP_NONE) && (rsp_step_y == STEP_NONE) &&
                       (rsp_step_z == STEP_NONE);

   // Every accepted item shows its result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("accepted item produced no result");

   // A stalled result stays valid and holds its status and done flag.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_move_done))
      else $error("stalled result changed");

   // A load result never carries steps or a done flag.
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_action == ACTION_LOAD) |=> steps_zero && !rsp_move_done)
      else $error("load result carried steps");

   // Any non-ok status carries no steps and no done flag.
   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> steps_zero && !rsp_move_done)
      else $error("rejected item carried steps");

   // A finished move means the final tick produced a dominant step.
   a_done_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_move_done |-> !steps_zero)
      else $error("move ended on a tick without a step");

endmodule

bind three_axis_line_step_interpolator li3_checker u_li3_checker (.*);
